// ===== src/sqg_pkg.sv =====
// Shared constants and tables for the single-qubit gate unit.
package sqg_pkg;

    localparam int AMP_WIDTH      = 16;
    localparam int ROTATION_STEPS = 16;
    localparam int CS_FRAC        = 30;
    localparam int ANG_W          = 34;
    localparam int CS_W           = 33;

    localparam logic [3:0] KIND_PREP0 = 4'd0;
    localparam logic [3:0] KIND_PREP1 = 4'd1;
    localparam logic [3:0] KIND_PLUS  = 4'd2;
    localparam logic [3:0] KIND_MINUS = 4'd3;
    localparam logic [3:0] KIND_X     = 4'd4;
    localparam logic [3:0] KIND_Y     = 4'd5;
    localparam logic [3:0] KIND_Z     = 4'd6;
    localparam logic [3:0] KIND_H     = 4'd7;
    localparam logic [3:0] KIND_S     = 4'd8;
    localparam logic [3:0] KIND_T     = 4'd9;
    localparam logic [3:0] KIND_RZ    = 4'd10;
    localparam logic [3:0] KIND_MEAS  = 4'd11;
    localparam logic [3:0] KIND_PEEK  = 4'd12;

    localparam logic signed [15:0] THETA_S = 16'sd8192;
    localparam logic signed [15:0] THETA_T = 16'sd4096;

    localparam logic [63:0] INV_SQRT2_Q62 = 64'd3260954456333195553;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd2147483648;

    function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/single_qubit_gate_unit.sv =====
// Single-qubit state vector unit: one gate, preparation or measurement per request.
// Preparation, Pauli and unused kinds go straight to writeback; measurement and peek
// first compute the outcome; Hadamard sums go through the shared multiplier; S, T
// and Rz run CORDIC iterations, then eight passes through the multiplier, then writeback.
// One request at a time: s_axis_tready is high only when idle and the result register is
// empty, so a new request waits until the last result has been taken.
// Reset (aresetn low, synchronous) sets the state to |0> and empties the output.
module single_qubit_gate_unit #(
    parameter int AMP_WIDTH      = sqg_pkg::AMP_WIDTH,
    parameter int ROTATION_STEPS = sqg_pkg::ROTATION_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[3:0], theta[19:4], random_fraction[35:20], zero pad to 40
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_alpha_re[15:0], out_alpha_im[31:16], out_beta_re[47:32], out_beta_im[63:48],
    // outcome[64], outcome_valid[65], zero pad to 72
    output logic [71:0] m_axis_tdata
);

    localparam int FRAC  = AMP_WIDTH - 2;
    localparam int CS_W  = sqg_pkg::CS_W;
    localparam int ANG_W = sqg_pkg::ANG_W;
    localparam int PW    = AMP_WIDTH + CS_W;
    localparam int ACC_W = PW + 2;
    localparam int IW    = $clog2(ROTATION_STEPS + 1);
    localparam int SQ_W  = 2 * AMP_WIDTH + 1;
    localparam logic signed [AMP_WIDTH-1:0] AMP_MAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
    localparam logic signed [AMP_WIDTH-1:0] AMP_MIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};
    localparam logic signed [AMP_WIDTH-1:0] ONE = AMP_WIDTH'(1) <<< FRAC;
    localparam logic [63:0] K64 = (sqg_pkg::INV_SQRT2_Q62 + (64'd1 << (61 - FRAC)))
                                  >> (62 - FRAC);
    localparam logic signed [CS_W-1:0] K_CS = CS_W'(K64);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CORD  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_MEAS  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic signed [AMP_WIDTH-1:0] a0r_reg, a0i_reg, a1r_reg, a1i_reg;
    logic signed [AMP_WIDTH-1:0] n0r_reg, n0i_reg, n1r_reg, n1i_reg;
    logic [3:0]  kind_reg;
    logic [15:0] u_reg;
    logic        is_h_reg;
    logic signed [CS_W-1:0]  cx_reg, cy_reg;
    logic signed [ANG_W-1:0] cz_reg;
    logic        flip_reg;
    logic [IW-1:0] iter_reg;
    logic [2:0]  mstep_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic        out_valid_reg, outcome_reg, ovalid_reg;
    logic [63:0] out_amp_reg;

    function automatic logic signed [AMP_WIDTH-1:0] sat_w(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(AMP_MAX)) return AMP_MAX;
        if (v < ACC_W'(AMP_MIN)) return AMP_MIN;
        return v[AMP_WIDTH-1:0];
    endfunction

    function automatic logic signed [AMP_WIDTH-1:0] neg_sat(input logic signed [AMP_WIDTH-1:0] v);
        if (v == AMP_MIN) return AMP_MAX;
        return -v;
    endfunction

    wire [3:0]  in_kind = s_axis_tdata[3:0];
    wire signed [15:0] in_theta = s_axis_tdata[19:4];
    wire [15:0] in_u = s_axis_tdata[35:20];
    wire        accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;

    // Rz angle fold
    logic signed [15:0]      th_sel;
    logic signed [ANG_W-1:0] z0;
    always_comb begin
        case (in_kind)
            sqg_pkg::KIND_S: th_sel = sqg_pkg::THETA_S;
            sqg_pkg::KIND_T: th_sel = sqg_pkg::THETA_T;
            default:         th_sel = in_theta;
        endcase
        z0 = ANG_W'(th_sel) <<< 16;
    end

    // Hadamard sums need an extra bit
    logic signed [AMP_WIDTH:0] h_sum;
    always_comb begin
        case (mstep_reg[1:0])
            2'd0: h_sum = {a0r_reg[AMP_WIDTH-1], a0r_reg} + {a1r_reg[AMP_WIDTH-1], a1r_reg};
            2'd1: h_sum = {a0i_reg[AMP_WIDTH-1], a0i_reg} + {a1i_reg[AMP_WIDTH-1], a1i_reg};
            2'd2: h_sum = {a0r_reg[AMP_WIDTH-1], a0r_reg} - {a1r_reg[AMP_WIDTH-1], a1r_reg};
            default: h_sum = {a0i_reg[AMP_WIDTH-1], a0i_reg} - {a1i_reg[AMP_WIDTH-1], a1i_reg};
        endcase
    end

    // shared multiplier operand select; Rz takes two products per output
    logic signed [AMP_WIDTH:0]   m_a;
    logic signed [CS_W-1:0]      m_b;
    logic                        m_sub;
    always_comb begin
        m_a = h_sum; m_b = K_CS; m_sub = 1'b0;
        if (!is_h_reg) begin
            case (mstep_reg)
                3'd0: begin m_a = (AMP_WIDTH+1)'(a0r_reg); m_b = cx_reg; end
                3'd1: begin m_a = (AMP_WIDTH+1)'(a0i_reg); m_b = cy_reg; end
                3'd2: begin m_a = (AMP_WIDTH+1)'(a0i_reg); m_b = cx_reg; end
                3'd3: begin m_a = (AMP_WIDTH+1)'(a0r_reg); m_b = cy_reg; m_sub = 1'b1; end
                3'd4: begin m_a = (AMP_WIDTH+1)'(a1r_reg); m_b = cx_reg; end
                3'd5: begin m_a = (AMP_WIDTH+1)'(a1i_reg); m_b = cy_reg; m_sub = 1'b1; end
                3'd6: begin m_a = (AMP_WIDTH+1)'(a1i_reg); m_b = cx_reg; end
                default: begin m_a = (AMP_WIDTH+1)'(a1r_reg); m_b = cy_reg; end
            endcase
        end
    end

    logic signed [PW-1:0] mul_out;
    always_comb begin
        mul_out = PW'(m_a * m_b);
    end

    // CORDIC step
    logic signed [CS_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] at;
    always_comb begin
        dx = cy_reg >>> iter_reg;
        dy = cx_reg >>> iter_reg;
        at = sqg_pkg::atan_lookup(5'(iter_reg));
    end

    // measurement
    logic [SQ_W-1:0] pr;
    logic [SQ_W+1:0] lhs;
    always_comb begin
        pr  = SQ_W'(a0r_reg * a0r_reg) + SQ_W'(a0i_reg * a0i_reg);
        lhs = (SQ_W+2)'(u_reg) << (2 * FRAC - 16);
    end
    wire meas_one = !(lhs < (SQ_W+2)'(pr));

    // rounding of the finished accumulation
    logic signed [ACC_W-1:0] acc_fin, rnd;
    logic [1:0] slot;
    always_comb begin
        if (is_h_reg) begin
            acc_fin = ACC_W'(mul_out);
            rnd = (acc_fin + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
        end else begin
            acc_fin = m_sub ? acc_reg - ACC_W'(mul_out) : acc_reg + ACC_W'(mul_out);
            rnd = (acc_fin + (ACC_W'(1) <<< (sqg_pkg::CS_FRAC - 1))) >>> sqg_pkg::CS_FRAC;
        end
        slot = is_h_reg ? mstep_reg[1:0] : mstep_reg[2:1];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) begin
                case (in_kind)
                    sqg_pkg::KIND_S, sqg_pkg::KIND_T, sqg_pkg::KIND_RZ: state_next = ST_CORD;
                    sqg_pkg::KIND_H: state_next = ST_MUL;
                    sqg_pkg::KIND_MEAS, sqg_pkg::KIND_PEEK: state_next = ST_MEAS;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_CORD: if (iter_reg == IW'(ROTATION_STEPS - 1)) state_next = ST_MUL;
            ST_MUL: if ((is_h_reg && mstep_reg == 3'd3) || mstep_reg == 3'd7)
                state_next = ST_DONE;
            ST_MEAS: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            a0r_reg       <= ONE;
            a0i_reg       <= '0;
            a1r_reg       <= '0;
            a1i_reg       <= '0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            mstep_reg     <= '0;
            is_h_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (accept) begin
                    kind_reg    <= in_kind;
                    u_reg       <= in_u;
                    is_h_reg    <= (in_kind == sqg_pkg::KIND_H);
                    iter_reg    <= '0;
                    mstep_reg   <= '0;
                    acc_reg     <= '0;
                    outcome_reg <= 1'b0;
                    ovalid_reg  <= 1'b0;
                    cx_reg      <= sqg_pkg::CORDIC_GAIN;
                    cy_reg      <= '0;
                    if (z0 > sqg_pkg::QUARTER_TURN) begin
                        cz_reg <= z0 - sqg_pkg::HALF_TURN; flip_reg <= 1'b1;
                    end else if (z0 < -sqg_pkg::QUARTER_TURN) begin
                        cz_reg <= z0 + sqg_pkg::HALF_TURN; flip_reg <= 1'b1;
                    end else begin
                        cz_reg <= z0; flip_reg <= 1'b0;
                    end
                    case (in_kind)
                        sqg_pkg::KIND_PREP0: begin
                            n0r_reg <= ONE; n0i_reg <= '0; n1r_reg <= '0; n1i_reg <= '0;
                        end
                        sqg_pkg::KIND_PREP1: begin
                            n0r_reg <= '0; n0i_reg <= '0; n1r_reg <= ONE; n1i_reg <= '0;
                        end
                        sqg_pkg::KIND_PLUS: begin
                            n0r_reg <= AMP_WIDTH'(K64); n0i_reg <= '0;
                            n1r_reg <= AMP_WIDTH'(K64); n1i_reg <= '0;
                        end
                        sqg_pkg::KIND_MINUS: begin
                            n0r_reg <= AMP_WIDTH'(K64); n0i_reg <= '0;
                            n1r_reg <= -AMP_WIDTH'(K64); n1i_reg <= '0;
                        end
                        sqg_pkg::KIND_X: begin
                            n0r_reg <= a1r_reg; n0i_reg <= a1i_reg;
                            n1r_reg <= a0r_reg; n1i_reg <= a0i_reg;
                        end
                        sqg_pkg::KIND_Y: begin
                            n0r_reg <= a1i_reg; n0i_reg <= neg_sat(a1r_reg);
                            n1r_reg <= neg_sat(a0i_reg); n1i_reg <= a0r_reg;
                        end
                        sqg_pkg::KIND_Z: begin
                            n0r_reg <= a0r_reg; n0i_reg <= a0i_reg;
                            n1r_reg <= neg_sat(a1r_reg); n1i_reg <= neg_sat(a1i_reg);
                        end
                        default: begin
                            n0r_reg <= a0r_reg; n0i_reg <= a0i_reg;
                            n1r_reg <= a1r_reg; n1i_reg <= a1i_reg;
                        end
                    endcase
                end
                ST_CORD: begin
                    if (cz_reg >= 0) cz_reg <= cz_reg - at;
                    else cz_reg <= cz_reg + at;
                    iter_reg <= iter_reg + IW'(1);
                    if (iter_reg == IW'(ROTATION_STEPS - 1) && flip_reg) begin
                        cx_reg <= (cz_reg >= 0) ? dx - cx_reg : -(cx_reg + dx);
                        cy_reg <= (cz_reg >= 0) ? -(cy_reg + dy) : dy - cy_reg;
                    end else if (cz_reg >= 0) begin
                        cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy;
                    end else begin
                        cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy;
                    end
                end
                ST_MUL: begin
                    mstep_reg <= mstep_reg + 3'd1;
                    if (is_h_reg || mstep_reg[0]) begin
                        acc_reg <= '0;
                        case (slot)
                            2'd0: n0r_reg <= sat_w(rnd);
                            2'd1: n0i_reg <= sat_w(rnd);
                            2'd2: n1r_reg <= sat_w(rnd);
                            default: n1i_reg <= sat_w(rnd);
                        endcase
                    end else begin
                        acc_reg <= acc_fin;
                    end
                end
                ST_MEAS: begin
                    outcome_reg <= meas_one;
                    ovalid_reg  <= 1'b1;
                    if (kind_reg == sqg_pkg::KIND_MEAS) begin
                        n0r_reg <= meas_one ? '0 : ONE; n0i_reg <= '0;
                        n1r_reg <= meas_one ? ONE : '0; n1i_reg <= '0;
                    end
                end
                ST_DONE: begin
                    a0r_reg <= n0r_reg; a0i_reg <= n0i_reg;
                    a1r_reg <= n1r_reg; a1i_reg <= n1i_reg;
                    out_amp_reg <= {16'(n1i_reg), 16'(n1r_reg), 16'(n0i_reg), 16'(n0r_reg)};
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, ovalid_reg, outcome_reg, out_amp_reg};

endmodule
